### rtl/mis_pkg.sv
// Package for the merge insertion sorter.
// Holds the word width and the control struct broadcast to the cell chain.
// No dependencies.
package mis_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [DATA_W-1:0] t_word;

    // Broadcast control for the cell chain.
    typedef struct packed {
        logic  ins;    // insert value, cells at and above the slot shift up
        logic  pop;    // cell 0 leaves, every cell takes its right neighbor
        t_word value;  // value being inserted
    } t_cell_ctl;

endpackage

### rtl/mis_if.sv
// Handshake channels of the merge insertion sorter: input word and result word.
// Valid/ready with payload, source and sink modports. No dependencies.
interface mis_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] item_value;
    logic        is_final;

    modport source (output valid, output item_value, output is_final, input ready);
    modport sink   (input valid, input item_value, input is_final, output ready);
endinterface

interface mis_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sorted_value;
    logic        end_of_list;
    logic        overflowed;

    modport source (output valid, output sorted_value, output end_of_list,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_list,
                    input overflowed, output ready);
endinterface

### rtl/mis_cell.sv
// One cell of the sorted chain: holds a single value, compares it with the
// broadcast value and trades words with its neighbors. Depends on mis_pkg.
module mis_cell (
    input  logic               i_clk,
    input  mis_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  mis_pkg::t_word     i_left_val,
    input  logic               i_left_ge,
    input  mis_pkg::t_word     i_right_val,
    output mis_pkg::t_word     o_val,
    output logic               o_ge
);
    import mis_pkg::*;

    t_word r_val;
    t_word n_val;

    // Slot is at or above the insertion point.
    assign o_ge = !i_occ || (i_ctl.value <= r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && o_ge) begin
            n_val = i_left_ge ? i_left_val : i_ctl.value;
        end else if (i_ctl.pop) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### rtl/merge_insertion_sorter_top.sv
// Insertion sorter built as a chain of MAX_ITEMS cells. Each accepted word is
// placed in one update: every cell compares it with its own value and the cells
// at and above the slot shift up by one. On the word marked final the chain
// drains from cell 0 in ascending order, one result word per cycle while the
// sink is ready; no input is taken until the last result has left. Words that
// arrive with the chain full are dropped and flagged on every result of that
// list. Depends on mis_pkg, mis_if and mis_cell.
module merge_insertion_sorter_top #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mis_in_if.sink      i_item,
    mis_out_if.source   o_sorted
);
    import mis_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic {S_FILL, S_EMIT} t_state;

    t_state     r_state;
    logic [CNT_W-1:0] r_count;
    logic       r_drop;

    t_cell_ctl  w_ctl;
    t_word      w_val [MAX_ITEMS];
    logic       w_ge  [MAX_ITEMS];
    logic       w_full;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_full    = (r_count == CNT_W'(MAX_ITEMS));
    assign w_in_acc  = i_item.valid && i_item.ready;
    assign w_out_acc = o_sorted.valid && o_sorted.ready;

    assign i_item.ready          = (r_state == S_FILL);
    assign o_sorted.valid        = (r_state == S_EMIT);
    assign o_sorted.sorted_value = w_val[0];
    assign o_sorted.end_of_list  = (r_count == CNT_W'(1));
    assign o_sorted.overflowed   = r_drop;

    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.pop   = w_out_acc;
    assign w_ctl.value = i_item.item_value;

    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
        mis_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CNT_W'(gi) < r_count),
            .i_left_val  ((gi == 0) ? t_word'(0) : w_val[(gi == 0) ? 0 : gi - 1]),
            .i_left_ge   ((gi == 0) ? 1'b0 : w_ge[(gi == 0) ? 0 : gi - 1]),
            .i_right_val ((gi == MAX_ITEMS - 1) ? t_word'(0)
                          : w_val[(gi == MAX_ITEMS - 1) ? gi : gi + 1]),
            .o_val       (w_val[gi]),
            .o_ge        (w_ge[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (r_state)
                S_FILL: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_item.is_final) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_acc) begin
                        r_count <= r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            r_drop  <= 1'b0;
                            r_state <= S_FILL;
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sorted.valid |-> (r_count != '0))
        else $error("result offered from an empty chain");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full) |=> r_drop)
        else $error("drop not flagged");

    a_list_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_sorted.end_of_list) |=>
            (r_count == '0) && !r_drop && i_item.ready)
        else $error("chain not emptied after last result");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("count beyond capacity");

endmodule
